// ----- hw/rtl/iee_pkg.sv -----
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types and constants of the infix expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int OUT_WIDTH       = 32;

	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_TIMES  = 8'h2A;
	localparam logic [7:0] CH_DIVIDE = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef enum logic [1:0] {
		OP_PLUS   = 2'd0,
		OP_MINUS  = 2'd1,
		OP_TIMES  = 2'd2,
		OP_DIVIDE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_DIV0 = 2'd1,
		ERR_OVF  = 2'd2
	} err_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_APPLY,
		S_ITER,
		S_FIX,
		S_SETOP,
		S_FINAL
	} state_t;

	typedef struct packed {
		logic load;
		logic digit;
		logic apply;
		logic step;
		logic fix;
		logic set_op;
		logic final_add;
	} dp_cmd_t;

	typedef struct packed {
		logic is_digit;
		logic is_op;
		logic last;
		logic iter_needed;
		logic iter_last;
		logic out_free;
	} dp_status_t;

endpackage

// ----- hw/rtl/iee_ctrl.sv -----
// ----------------------------------------------------------------------------
// iee_ctrl
// Sequencer of the evaluator: steps each item through decode, operator
// apply, multiply/divide iterations and the closing sum.
// ----------------------------------------------------------------------------
module iee_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  iee_pkg::dp_status_t  st,
	output iee_pkg::dp_cmd_t     cmd
);

	iee_pkg::state_t state_q, state_d;
	logic            fin_q, fin_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iee_pkg::S_IDLE;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			fin_q   <= fin_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		fin_d   = fin_q;
		case (state_q)
			iee_pkg::S_IDLE: begin
				if (item_valid) state_d = iee_pkg::S_EXEC;
			end
			iee_pkg::S_EXEC: begin
				if (st.is_op) begin
					state_d = iee_pkg::S_APPLY;
					fin_d   = 1'b0;
				end else if (st.last) begin
					state_d = iee_pkg::S_APPLY;
					fin_d   = 1'b1;
				end else begin
					state_d = iee_pkg::S_IDLE;
				end
			end
			iee_pkg::S_APPLY: begin
				if (st.iter_needed) state_d = iee_pkg::S_ITER;
				else state_d = fin_q ? iee_pkg::S_FINAL : iee_pkg::S_SETOP;
			end
			iee_pkg::S_ITER: begin
				if (st.iter_last) state_d = iee_pkg::S_FIX;
			end
			iee_pkg::S_FIX: begin
				state_d = fin_q ? iee_pkg::S_FINAL : iee_pkg::S_SETOP;
			end
			iee_pkg::S_SETOP: begin
				if (st.last) begin
					state_d = iee_pkg::S_APPLY;
					fin_d   = 1'b1;
				end else begin
					state_d = iee_pkg::S_IDLE;
				end
			end
			iee_pkg::S_FINAL: begin
				if (st.out_free) state_d = iee_pkg::S_IDLE;
			end
			default: state_d = iee_pkg::S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			iee_pkg::S_IDLE: begin
				item_ready = 1'b1;
				cmd.load   = item_valid;
			end
			iee_pkg::S_EXEC:  cmd.digit     = st.is_digit;
			iee_pkg::S_APPLY: cmd.apply     = 1'b1;
			iee_pkg::S_ITER:  cmd.step      = 1'b1;
			iee_pkg::S_FIX:   cmd.fix       = 1'b1;
			iee_pkg::S_SETOP: cmd.set_op    = 1'b1;
			iee_pkg::S_FINAL: cmd.final_add = st.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ----- hw/rtl/iee_dp.sv -----
// ----------------------------------------------------------------------------
// iee_dp
// Datapath of the evaluator: running sum, pending term, number being built,
// pending operator, error latch, bit-serial multiply/divide unit and the
// result register.
// ----------------------------------------------------------------------------
module iee_dp #(
	parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [7:0]                        ch,
	input  logic                              last,
	input  iee_pkg::dp_cmd_t                  cmd,
	output iee_pkg::dp_status_t               st,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic [iee_pkg::OUT_WIDTH-1:0]     value,
	output logic [1:0]                        status
);

	localparam int W  = VALUE_WIDTH;
	localparam int CW = $clog2(W);
	localparam int OW = iee_pkg::OUT_WIDTH;

	// expression state
	logic [W-1:0]  sum_q, sum_d;
	logic [W-1:0]  term_q, term_d;
	logic [W-1:0]  cur_q, cur_d;
	iee_pkg::op_t  op_q, op_d;
	iee_pkg::err_t err_q, err_d;

	// held item
	logic [7:0] ch_q;
	logic       last_q;

	// serial multiply/divide unit
	logic [2*W-1:0] p_q, p_next;
	logic [W-1:0]   b_q;
	logic           neg_q;
	logic           div_q;
	logic [CW-1:0]  cnt_q;

	// result register
	logic [OW-1:0]  value_q;
	iee_pkg::err_t  status_q;
	logic           result_valid_q;

	logic [W-1:0]   vmax;
	logic [W+3:0]   dig_next;
	logic           dig_ovf;
	logic [W:0]     add_sum;
	logic           add_ovf;
	logic [W-1:0]   neg_cur;
	logic [W-1:0]   mag_term, mag_cur;
	logic           no_err;
	logic           iter_needed;
	iee_pkg::op_t   op_dec;
	logic [W:0]     mul_hi;
	logic [2*W-1:0] div_sh;
	logic [W:0]     div_trial;
	logic [2*W-1:0] fix_res, fix_lim;
	logic           fix_ovf;
	logic [W-1:0]   fix_val;
	logic [W-1:0]   fin_val;
	logic [OW-1:0]  fin_ext;
	iee_pkg::err_t  fin_err;

	assign vmax     = {1'b0, {(W-1){1'b1}}};
	assign no_err   = (err_q == iee_pkg::ERR_NONE);
	assign neg_cur  = ~cur_q + W'(1);
	assign mag_term = term_q[W-1] ? (~term_q + W'(1)) : term_q;
	assign mag_cur  = cur_q[W-1] ? (~cur_q + W'(1)) : cur_q;

	// number accumulation: cur * 10 + digit, checked against the top of range
	assign dig_next = ({4'b0, cur_q} << 3) + ({4'b0, cur_q} << 1)
		+ {{W{1'b0}}, ch_q[3:0]};
	assign dig_ovf  = dig_next > {4'b0, vmax};

	assign add_sum = {sum_q[W-1], sum_q} + {term_q[W-1], term_q};
	assign add_ovf = add_sum[W] ^ add_sum[W-1];

	assign iter_needed = no_err
		&& (((op_q == iee_pkg::OP_TIMES) && (term_q != '0) && (cur_q != '0))
		|| ((op_q == iee_pkg::OP_DIVIDE) && (cur_q != '0)));

	always_comb begin
		case (ch_q)
			iee_pkg::CH_PLUS:  op_dec = iee_pkg::OP_PLUS;
			iee_pkg::CH_MINUS: op_dec = iee_pkg::OP_MINUS;
			iee_pkg::CH_TIMES: op_dec = iee_pkg::OP_TIMES;
			default:           op_dec = iee_pkg::OP_DIVIDE;
		endcase
	end

	// one multiply (shift-add) or restoring divide step
	assign mul_hi    = {1'b0, p_q[2*W-1:W]} + (p_q[0] ? {1'b0, b_q} : {(W+1){1'b0}});
	assign div_sh    = {p_q[2*W-2:0], 1'b0};
	assign div_trial = {1'b0, div_sh[2*W-1:W]} - {1'b0, b_q};

	always_comb begin
		if (div_q) begin
			if (!div_trial[W]) p_next = {div_trial[W-1:0], div_sh[W-1:1], 1'b1};
			else p_next = div_sh;
		end else begin
			p_next = {mul_hi, p_q[W-1:1]};
		end
	end

	// range check of the finished magnitude and sign restore
	assign fix_res = div_q ? {{W{1'b0}}, p_q[W-1:0]} : p_q;
	assign fix_lim = {{(W+1){1'b0}}, {(W-1){1'b1}}} + {{(2*W-1){1'b0}}, neg_q};
	assign fix_ovf = fix_res > fix_lim;
	assign fix_val = neg_q ? (~fix_res[W-1:0] + W'(1)) : fix_res[W-1:0];

	// closing sum
	always_comb begin
		if (!no_err) fin_err = err_q;
		else if (add_ovf) fin_err = iee_pkg::ERR_OVF;
		else fin_err = iee_pkg::ERR_NONE;
	end
	assign fin_val = (fin_err == iee_pkg::ERR_NONE) ? add_sum[W-1:0] : '0;

	generate
		if (W >= OW) begin : g_trunc
			assign fin_ext = fin_val[OW-1:0];
		end else begin : g_sext
			assign fin_ext = {{(OW-W){fin_val[W-1]}}, fin_val};
		end
	endgenerate

	always_comb begin
		sum_d  = sum_q;
		term_d = term_q;
		cur_d  = cur_q;
		op_d   = op_q;
		err_d  = err_q;
		if (cmd.digit && no_err) begin
			if (dig_ovf) begin
				err_d = iee_pkg::ERR_OVF;
				cur_d = '0;
			end else begin
				cur_d = dig_next[W-1:0];
			end
		end
		if (cmd.apply && no_err) begin
			case (op_q)
				iee_pkg::OP_PLUS, iee_pkg::OP_MINUS: begin
					if (add_ovf) begin
						err_d = iee_pkg::ERR_OVF;
						sum_d = '0;
					end else begin
						sum_d = add_sum[W-1:0];
					end
					term_d = (op_q == iee_pkg::OP_MINUS) ? neg_cur : cur_q;
				end
				iee_pkg::OP_TIMES: begin
					if (!iter_needed) term_d = '0;
				end
				default: begin
					if (cur_q == '0) begin
						err_d  = iee_pkg::ERR_DIV0;
						term_d = '0;
					end
				end
			endcase
		end
		if (cmd.fix) begin
			if (fix_ovf) begin
				err_d  = iee_pkg::ERR_OVF;
				term_d = '0;
			end else begin
				term_d = fix_val;
			end
		end
		if (cmd.set_op) begin
			op_d  = op_dec;
			cur_d = '0;
		end
		if (cmd.final_add) begin
			sum_d  = '0;
			term_d = '0;
			cur_d  = '0;
			op_d   = iee_pkg::OP_PLUS;
			err_d  = iee_pkg::ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q          <= '0;
			term_q         <= '0;
			cur_q          <= '0;
			op_q           <= iee_pkg::OP_PLUS;
			err_q          <= iee_pkg::ERR_NONE;
			result_valid_q <= 1'b0;
		end else begin
			sum_q  <= sum_d;
			term_q <= term_d;
			cur_q  <= cur_d;
			op_q   <= op_d;
			err_q  <= err_d;
			if (cmd.final_add) result_valid_q <= 1'b1;
			else if (result_ready) result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q   <= ch;
			last_q <= last;
		end
		if (cmd.apply) begin
			p_q   <= {{W{1'b0}}, (op_q == iee_pkg::OP_DIVIDE) ? mag_term : mag_cur};
			b_q   <= (op_q == iee_pkg::OP_DIVIDE) ? mag_cur : mag_term;
			neg_q <= term_q[W-1] ^ cur_q[W-1];
			div_q <= (op_q == iee_pkg::OP_DIVIDE);
			cnt_q <= CW'(W - 1);
		end else if (cmd.step) begin
			p_q   <= p_next;
			cnt_q <= cnt_q - CW'(1);
		end
		if (cmd.final_add) begin
			value_q  <= fin_ext;
			status_q <= fin_err;
		end
	end

	always_comb begin
		st             = '0;
		st.is_digit    = ch_q inside {[iee_pkg::CH_ZERO:iee_pkg::CH_NINE]};
		st.is_op       = (ch_q == iee_pkg::CH_PLUS) || (ch_q == iee_pkg::CH_MINUS)
			|| (ch_q == iee_pkg::CH_TIMES) || (ch_q == iee_pkg::CH_DIVIDE);
		st.last        = last_q;
		st.iter_needed = iter_needed;
		st.iter_last   = (cnt_q == '0);
		st.out_free    = !result_valid_q || result_ready;
	end

	assign result_valid = result_valid_q;
	assign value        = value_q;
	assign status       = status_q;

endmodule

// ----- hw/rtl/infix_expression_evaluator.sv -----
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// Digit or ignored item: accept, execute. Operator item: accept, execute, apply,
// set operator, with iteration and fix steps after apply when it closes a pending
// * or / that runs the one-bit-per-cycle multiply/divide unit. The last item adds
// one more apply pass (iterating likewise for * or /) and a closing step, held until
// the result register is free; the result waits there while the next item is taken.
// Reset (arst_n low) clears sum, term, number, error and drops any result.
// ----------------------------------------------------------------------------
module infix_expression_evaluator #(
	parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic [7:0]                    ch,
	input  logic                          last,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [iee_pkg::OUT_WIDTH-1:0] value,
	output logic [1:0]                    status
);

	// Evaluation keeps a running sum and one open product term, so * and /
	// bind tighter than + and - without any operand stack. An operator item
	// folds the pending operator into the state; the last item folds once
	// more and adds the open term to the sum.

	iee_pkg::dp_cmd_t    cmd;
	iee_pkg::dp_status_t st;

	// sequencer: one state per phase of item handling
	iee_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.st         (st),
		.cmd        (cmd)
	);

	// datapath: expression state, serial mul/div unit, result register
	iee_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ch           (ch),
		.last         (last),
		.cmd          (cmd),
		.st           (st),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.value        (value),
		.status       (status)
	);

	// an accepted item moves the sequencer to its execute state, where no item is accepted
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while previous item still executing");

	// an error result carries zero as its value
	a_err_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != 2'(iee_pkg::ERR_NONE)) |-> (value == '0))
		else $error("error result with nonzero value");

	// a new result only appears out of the closing cycle, never from idle
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!item_ready))
		else $error("result appeared without a closing cycle");

endmodule

// ----- dv/infix_expression_evaluator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// infix_expression_evaluator_tb
// Streams ASCII expressions into the evaluator one character per item and
// checks each value/status result against an in-bench running-sum evaluator.
// A short directed set comes first, then random expressions with noise,
// missing operands, huge numbers and zero divisors. Both sides idle at random.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_tb;

	localparam longint VAL_MAX    = (longint'(1) <<< (iee_pkg::VALUE_WIDTH_DEF - 1)) - 1;
	localparam longint VAL_MIN    = -VAL_MAX - 1;
	localparam int     ITEM_GOAL  = 1050;
	localparam int     LONG_HOLD  = 400;
	localparam int     DRAIN_WAIT = 2 * iee_pkg::VALUE_WIDTH_DEF + 16;

	typedef struct {
		logic [7:0] ch;
		logic       last;
		logic       sync;   // wait for every pending result before offering this item
	} char_item_t;

	typedef struct {
		logic [iee_pkg::OUT_WIDTH-1:0] value;
		iee_pkg::err_t                 status;
	} eval_result_t;

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          item_valid   = 1'b0;
	logic                          item_ready;
	logic [7:0]                    ch           = '0;
	logic                          last         = 1'b0;
	logic                          result_valid;
	logic                          result_ready = 1'b0;
	logic [iee_pkg::OUT_WIDTH-1:0] value;
	logic [1:0]                    status;

	char_item_t   char_feed[$];
	eval_result_t awaited_evals[$];
	int           counted_items = 0;
	int           failures      = 0;
	int           results_seen  = 0;
	int           send_gap      = 0;
	int           hold_left     = 0;
	logic [11:0]  cyc           = '0;
	logic         calm;

	// Evaluator state, mirrors what the block keeps between characters.
	longint        sum_acc;
	longint        term_acc;
	longint        num_acc;
	iee_pkg::op_t  op_pend;
	iee_pkg::err_t err_latch;

	infix_expression_evaluator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.ch           (ch),
		.last         (last),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.value        (value),
		.status       (status)
	);

	always #4 clk = ~clk;

	// Whenever cyc[9:8] is zero, a quarter of the time, neither side picks a random idle gap.
	always @(posedge clk) begin
		cyc <= cyc + 1'b1;
	end
	assign calm = (cyc[9:8] == 2'b00);

	// ------------------------------------------------------------------
	// Evaluator
	// ------------------------------------------------------------------
	function automatic void clear_eval();
		sum_acc   = 0;
		term_acc  = 0;
		num_acc   = 0;
		op_pend   = iee_pkg::OP_PLUS;
		err_latch = iee_pkg::ERR_NONE;
	endfunction

	// First error wins: later errors never replace a latched one.
	function automatic void flag_error(iee_pkg::err_t code);
		if (err_latch == iee_pkg::ERR_NONE) begin
			err_latch = code;
		end
	endfunction

	function automatic longint chk_add(longint a, longint b);
		longint s;
		s = a + b;
		if (s > VAL_MAX || s < VAL_MIN) begin
			flag_error(iee_pkg::ERR_OVF);
			return 0;
		end
		return s;
	endfunction

	// Operands stay within 32-bit range, so the 64-bit product is exact.
	function automatic longint chk_mul(longint a, longint b);
		longint p;
		p = a * b;
		if (p > VAL_MAX || p < VAL_MIN) begin
			flag_error(iee_pkg::ERR_OVF);
			return 0;
		end
		return p;
	endfunction

	function automatic longint chk_div(longint a, longint b);
		if (b == 0) begin
			flag_error(iee_pkg::ERR_DIV0);
			return 0;
		end
		if (a == VAL_MIN && b == -1) begin
			flag_error(iee_pkg::ERR_OVF);
			return 0;
		end
		return a / b;
	endfunction

	// Close the number just read against the pending operator.
	function automatic void fold_pending();
		if (err_latch != iee_pkg::ERR_NONE) begin
			return;
		end
		case (op_pend)
			iee_pkg::OP_PLUS: begin
				sum_acc  = chk_add(sum_acc, term_acc);
				term_acc = num_acc;
			end
			iee_pkg::OP_MINUS: begin
				sum_acc  = chk_add(sum_acc, term_acc);
				term_acc = -num_acc;
			end
			iee_pkg::OP_TIMES: begin
				term_acc = chk_mul(term_acc, num_acc);
			end
			default: begin
				term_acc = chk_div(term_acc, num_acc);
			end
		endcase
	endfunction

	// Advance the evaluator by one accepted character; queue a result on last.
	function automatic void evaluate_char(logic [7:0] c, logic is_last);
		longint       d;
		longint       v;
		eval_result_t res;
		if (c >= iee_pkg::CH_ZERO && c <= iee_pkg::CH_NINE) begin
			d = longint'(c - iee_pkg::CH_ZERO);
			if (err_latch == iee_pkg::ERR_NONE) begin
				if (num_acc > (VAL_MAX - d) / 10) begin
					flag_error(iee_pkg::ERR_OVF);
					num_acc = 0;
				end else begin
					num_acc = num_acc * 10 + d;
				end
			end
		end else if (c == iee_pkg::CH_PLUS || c == iee_pkg::CH_MINUS ||
				c == iee_pkg::CH_TIMES || c == iee_pkg::CH_DIVIDE) begin
			fold_pending();
			case (c)
				iee_pkg::CH_PLUS:  op_pend = iee_pkg::OP_PLUS;
				iee_pkg::CH_MINUS: op_pend = iee_pkg::OP_MINUS;
				iee_pkg::CH_TIMES: op_pend = iee_pkg::OP_TIMES;
				default:           op_pend = iee_pkg::OP_DIVIDE;
			endcase
			num_acc = 0;
		end
		if (!is_last) begin
			return;
		end
		fold_pending();
		v = 0;
		if (err_latch == iee_pkg::ERR_NONE) begin
			v = chk_add(sum_acc, term_acc);
		end
		if (err_latch != iee_pkg::ERR_NONE) begin
			v = 0;
		end
		res.value  = v[iee_pkg::OUT_WIDTH-1:0];
		res.status = err_latch;
		awaited_evals.push_back(res);
		clear_eval();
	endfunction

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------
	// Mostly short gaps, a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_op();
		case ($urandom_range(0, 3))
			0:       return iee_pkg::CH_PLUS;
			1:       return iee_pkg::CH_MINUS;
			2:       return iee_pkg::CH_TIMES;
			default: return iee_pkg::CH_DIVIDE;
		endcase
	endfunction

	function automatic void push_char(logic [7:0] c);
		char_item_t it;
		it.ch   = c;
		it.last = 1'b0;
		it.sync = 1'b0;
		char_feed.push_back(it);
		counted_items++;
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			push_char(s[i]);
		end
		char_feed[char_feed.size()-1].last = 1'b1;
	endfunction

	// Decimal operand, mostly small, sometimes at or past the 32-bit edge.
	function automatic void push_number();
		longint unsigned n;
		string           s;
		int              r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			n = $urandom_range(0, 9);
		end else if (r < 75) begin
			n = $urandom_range(0, 999);
		end else if (r < 88) begin
			n = $urandom_range(0, 99999);
		end else if (r < 95) begin
			case ($urandom_range(0, 6))
				0:       n = 64'd2147483647;
				1:       n = 64'd2147483648;
				2:       n = 64'd1073741824;
				3:       n = 64'd46340;
				4:       n = 64'd46341;
				5:       n = 64'd65536;
				default: n = 64'd99999999999;
			endcase
		end else begin
			n = $urandom;
		end
		s = $sformatf("%0d", n);
		for (int i = 0; i < s.len(); i++) begin
			push_char(s[i]);
			if ($urandom_range(0, 24) == 0) push_char(8'h20);
			if ($urandom_range(0, 39) == 0) push_char(8'($urandom_range(0, 255)));
		end
	endfunction

	// One random expression; broken forms (missing operands, doubled or
	// trailing operators) come in at a low rate.
	function automatic void push_expr(bit sync);
		int start;
		int n_terms;
		start   = char_feed.size();
		n_terms = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
		for (int t = 0; t < n_terms; t++) begin
			if (t > 0 || $urandom_range(0, 9) == 0) begin
				push_char(pick_op());
				if ($urandom_range(0, 19) == 0) push_char(pick_op());
			end
			if ($urandom_range(0, 11) != 0) push_number();
			if ($urandom_range(0, 29) == 0) push_char(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 14) == 0) push_char(pick_op());
		if (char_feed.size() == start) begin
			push_char(iee_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
		end
		char_feed[start].sync               = sync;
		char_feed[char_feed.size()-1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Driver: offer the next character, hold it until accepted
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		char_item_t nxt;
		if (!arst_n) begin
			item_valid <= 1'b0;
			ch         <= '0;
			last       <= 1'b0;
			send_gap   = 0;
		end else begin
			if (item_valid && item_ready) begin
				evaluate_char(ch, last);
			end
			if (!item_valid || item_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					item_valid <= 1'b0;
				end else if (char_feed.size() > 0 &&
						!(char_feed[0].sync && awaited_evals.size() > 0)) begin
					nxt = char_feed.pop_front();
					item_valid <= 1'b1;
					ch         <= nxt.ch;
					last       <= nxt.last;
					send_gap   = calm ? 0 : pick_gap();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check each result, stall the output at random
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		eval_result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
			hold_left    = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (awaited_evals.size() == 0) begin
					$error("result with no expression pending: value=%0d status=%0d",
						$signed(value), status);
					failures++;
				end else begin
					want = awaited_evals.pop_front();
					if (value !== want.value) begin
						$error("value: expected %0d, got %0d",
							$signed(want.value), $signed(value));
						failures++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						failures++;
					end
				end
				results_seen++;
				// Long back-pressure so the block fills up and stalls its input.
				if (results_seen == 15 || results_seen == 45) begin
					hold_left = LONG_HOLD;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
				hold_left    = calm ? 0 : pick_gap();
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		int n_expr;
		clear_eval();

		// Directed: zero divisor, leading operators, trailing divide,
		// ignored bytes between digits, sum overflow at the signed limit.
		push_text("9/0");
		push_text("*-3");
		push_text("8/");
		push_char(8'h31);
		push_char(8'h20);
		push_char(8'h32);
		push_char(8'hFF);
		push_char(iee_pkg::CH_PLUS);
		push_char(8'h00);
		char_feed[char_feed.size()-1].last = 1'b1;
		push_text("2147483647+1");

		n_expr = 0;
		while (counted_items < ITEM_GOAL) begin
			// Pause the sender twice until the block has drained.
			push_expr(n_expr == 20 || n_expr == 50);
			n_expr++;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (char_feed.size() > 0 || item_valid || awaited_evals.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
